FILE: hw/rtl/mtt_pkg.sv
// shared types, constants and register map for the millisecond timebase
package mtt_pkg;

    // default channel counts
    localparam int UART_CHANNELS_DEF    = 2;
    localparam int CAPTURE_CHANNELS_DEF = 8;

    // widths fixed by the transaction fields
    localparam int MS_W      = 10;
    localparam int TIME_W    = 6;
    localparam int DIGIT_W   = 4;
    localparam int SHOT_W    = 11;
    localparam int UART_W    = 16;
    localparam int IDLE_W    = 8;
    localparam int DELAY_W   = 16;
    localparam int EXP_W     = 2;
    localparam int STALE_W   = 8;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // time constants
    localparam logic [MS_W-1:0]    MS_LAST    = MS_W'(999);
    localparam logic [DIGIT_W-1:0] DIGIT_LAST = DIGIT_W'(9);
    localparam logic [TIME_W-1:0]  SIXTY_LAST = TIME_W'(59);

    // action codes
    localparam logic [2:0] ACT_TICK        = 3'd0;
    localparam logic [2:0] ACT_ARM_ONESHOT = 3'd1;
    localparam logic [2:0] ACT_ARM_UART    = 3'd2;
    localparam logic [2:0] ACT_CAPTURE     = 3'd3;
    localparam logic [2:0] ACT_LOAD_DELAY  = 3'd4;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SCAN_MODE    = 3'd0;
    localparam logic [2:0] REG_CAPTURE_USE  = 3'd1;
    localparam logic [2:0] REG_UART_LIMIT   = 3'd2;
    localparam logic [2:0] REG_IDLE_LIMIT   = 3'd3;
    localparam logic [2:0] REG_ONESHOT_LEN  = 3'd4;

    // register reset values
    localparam logic              SCAN_MODE_RST   = 1'b1;
    localparam logic [STALE_W-1:0] CAPTURE_USE_RST = '0;
    localparam logic [UART_W-1:0] UART_LIMIT_RST  = UART_W'(10);
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST  = IDLE_W'(3);
    localparam logic [SHOT_W-1:0] ONESHOT_LEN_RST = SHOT_W'(1500);

    typedef struct packed {
        logic [2:0]         action;
        logic [2:0]         channel;
        logic [DELAY_W-1:0] delay_value;
    } item_t;

    typedef struct packed {
        logic               pulse_10ms;
        logic               pulse_100ms;
        logic               pulse_1s;
        logic               pulse_1min;
        logic               scan_pulse;
        logic               oneshot_busy;
        logic [EXP_W-1:0]   uart_expired;
        logic [STALE_W-1:0] capture_stale;
        logic [DELAY_W-1:0] startup_left;
        logic [TIME_W-1:0]  seconds_now;
        logic [TIME_W-1:0]  minutes_now;
        logic [MS_W-1:0]    millis_now;
    } result_t;

endpackage

FILE: hw/rtl/millisecond_timebase_and_timeouts_core.sv
// millisecond timebase with one-shot, uart, capture idle and startup timers
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------
//  item     | in        | item_valid/item_stall | mtt_pkg::item_t
//  result   | out       | result_valid/result_stall | mtt_pkg::result_t
//  config   | in        | apb psel/penable     | 32-bit registers
//
// one transaction per cycle sustained while result_stall lets the result register drain;
// an input register is followed by the single-pass update into the result register.
// rst_n clears all counters and loads register defaults asynchronously.
// a held result stalls the input register only when that register is full;
// item_stall follows result_stall in the same cycle.
module millisecond_timebase_and_timeouts_core #(
    parameter int UART_CHANNELS    = mtt_pkg::UART_CHANNELS_DEF,
    parameter int CAPTURE_CHANNELS = mtt_pkg::CAPTURE_CHANNELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  mtt_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output mtt_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mtt_pkg::ADDR_W-1:0] paddr,
    input  logic [mtt_pkg::DATA_W-1:0] pwdata,
    output logic [mtt_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    // configuration registers
    logic                                scan_mode_reg;
    logic [CAPTURE_CHANNELS-1:0]         capture_use_reg;
    logic [mtt_pkg::UART_W-1:0]          uart_limit_reg;
    logic [mtt_pkg::IDLE_W-1:0]          idle_limit_reg;
    logic [mtt_pkg::SHOT_W-1:0]          oneshot_len_reg;

    // pipeline registers
    logic                                in_valid_reg;
    mtt_pkg::item_t                      in_data_reg;
    logic                                out_valid_reg;
    mtt_pkg::result_t                    out_data_reg, out_data_next;

    // timebase state
    logic [mtt_pkg::MS_W-1:0]            ms_reg, ms_next;
    logic [mtt_pkg::DIGIT_W-1:0]         ones_reg, ones_next;
    logic [mtt_pkg::DIGIT_W-1:0]         tens_reg, tens_next;
    logic [mtt_pkg::TIME_W-1:0]          sec_reg, sec_next;
    logic [mtt_pkg::TIME_W-1:0]          min_reg, min_next;
    logic                                shot_on_reg, shot_on_next;
    logic [mtt_pkg::SHOT_W-1:0]          shot_elapsed_reg, shot_elapsed_next;
    logic [UART_CHANNELS-1:0]            uart_armed_reg, uart_armed_next;
    logic [mtt_pkg::UART_W-1:0]          uart_elapsed_reg [UART_CHANNELS];
    logic [mtt_pkg::UART_W-1:0]          uart_elapsed_next [UART_CHANNELS];
    logic [mtt_pkg::IDLE_W-1:0]          idle_reg [CAPTURE_CHANNELS];
    logic [mtt_pkg::IDLE_W-1:0]          idle_next [CAPTURE_CHANNELS];
    logic [mtt_pkg::DELAY_W-1:0]         startup_reg, startup_next;

    // combinational helpers
    logic                                out_free;
    logic                                fire;
    logic                                cfg_write;
    logic [2:0]                          cfg_index;
    logic                                p10, p100, p1s, p1min;
    logic [UART_CHANNELS-1:0]            uart_fired;
    logic [mtt_pkg::SHOT_W-1:0]          shot_inc;

    // handshake control
    assign out_free     = !out_valid_reg || !result_stall;
    assign fire         = in_valid_reg && out_free;
    assign item_stall   = in_valid_reg && !out_free;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // config port decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    // register read mux
    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            mtt_pkg::REG_SCAN_MODE:   prdata = mtt_pkg::DATA_W'(scan_mode_reg);
            mtt_pkg::REG_CAPTURE_USE: prdata = mtt_pkg::DATA_W'(capture_use_reg);
            mtt_pkg::REG_UART_LIMIT:  prdata = mtt_pkg::DATA_W'(uart_limit_reg);
            mtt_pkg::REG_IDLE_LIMIT:  prdata = mtt_pkg::DATA_W'(idle_limit_reg);
            mtt_pkg::REG_ONESHOT_LEN: prdata = mtt_pkg::DATA_W'(oneshot_len_reg);
            default:                  prdata = '0;
        endcase
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg   <= mtt_pkg::SCAN_MODE_RST;
            capture_use_reg <= CAPTURE_CHANNELS'(mtt_pkg::CAPTURE_USE_RST);
            uart_limit_reg  <= mtt_pkg::UART_LIMIT_RST;
            idle_limit_reg  <= mtt_pkg::IDLE_LIMIT_RST;
            oneshot_len_reg <= mtt_pkg::ONESHOT_LEN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mtt_pkg::REG_SCAN_MODE:   scan_mode_reg   <= pwdata[0];
                mtt_pkg::REG_CAPTURE_USE: capture_use_reg <= pwdata[CAPTURE_CHANNELS-1:0];
                mtt_pkg::REG_UART_LIMIT:  uart_limit_reg  <= pwdata[mtt_pkg::UART_W-1:0];
                mtt_pkg::REG_IDLE_LIMIT:  idle_limit_reg  <= pwdata[mtt_pkg::IDLE_W-1:0];
                mtt_pkg::REG_ONESHOT_LEN: oneshot_len_reg <= pwdata[mtt_pkg::SHOT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_data_reg <= item;
        end
    end

    // single-pass state update
    always_comb
    begin
        ms_next           = ms_reg;
        ones_next         = ones_reg;
        tens_next         = tens_reg;
        sec_next          = sec_reg;
        min_next          = min_reg;
        shot_on_next      = shot_on_reg;
        shot_elapsed_next = shot_elapsed_reg;
        uart_armed_next   = uart_armed_reg;
        uart_elapsed_next = uart_elapsed_reg;
        idle_next         = idle_reg;
        startup_next      = startup_reg;
        uart_fired        = '0;
        p10               = 1'b0;
        p100              = 1'b0;
        p1s               = 1'b0;
        p1min             = 1'b0;
        shot_inc          = shot_elapsed_reg + 1'b1;

        if (fire)
        begin
            case (in_data_reg.action)
                mtt_pkg::ACT_TICK:
                begin
                    // decimal digit counters give the 10 ms and 100 ms marks
                    p10  = (ones_reg == mtt_pkg::DIGIT_LAST);
                    p100 = p10 && (tens_reg == mtt_pkg::DIGIT_LAST);
                    p1s  = (ms_reg == mtt_pkg::MS_LAST);
                    ones_next = p10 ? '0 : ones_reg + 1'b1;
                    if (p10)
                    begin
                        tens_next = (tens_reg == mtt_pkg::DIGIT_LAST) ? '0 : tens_reg + 1'b1;
                    end
                    ms_next = p1s ? '0 : ms_reg + 1'b1;

                    // one-shot
                    if (shot_on_reg)
                    begin
                        if (shot_inc >= oneshot_len_reg)
                        begin
                            shot_elapsed_next = '0;
                            shot_on_next      = 1'b0;
                        end
                        else
                        begin
                            shot_elapsed_next = shot_inc;
                        end
                    end

                    // uart receive timeouts
                    for (int i = 0; i < UART_CHANNELS; i++)
                    begin
                        if (uart_armed_reg[i])
                        begin
                            if (uart_elapsed_reg[i] < uart_limit_reg)
                            begin
                                uart_elapsed_next[i] = uart_elapsed_reg[i] + 1'b1;
                            end
                            else
                            begin
                                uart_elapsed_next[i] = '0;
                                uart_armed_next[i]   = 1'b0;
                                uart_fired[i]        = 1'b1;
                            end
                        end
                    end

                    // second boundary
                    if (p1s)
                    begin
                        for (int i = 0; i < CAPTURE_CHANNELS; i++)
                        begin
                            if (capture_use_reg[i] && (idle_reg[i] < idle_limit_reg))
                            begin
                                idle_next[i] = idle_reg[i] + 1'b1;
                            end
                        end
                        if (startup_reg != '0)
                        begin
                            startup_next = startup_reg - 1'b1;
                        end
                        if (sec_reg == mtt_pkg::SIXTY_LAST)
                        begin
                            sec_next = '0;
                            p1min    = 1'b1;
                            min_next = (min_reg == mtt_pkg::SIXTY_LAST) ? '0 : min_reg + 1'b1;
                        end
                        else
                        begin
                            sec_next = sec_reg + 1'b1;
                        end
                    end
                end

                mtt_pkg::ACT_ARM_ONESHOT:
                begin
                    shot_on_next      = 1'b1;
                    shot_elapsed_next = '0;
                end

                mtt_pkg::ACT_ARM_UART:
                begin
                    for (int i = 0; i < UART_CHANNELS; i++)
                    begin
                        if (in_data_reg.channel == 3'(i))
                        begin
                            uart_armed_next[i]   = 1'b1;
                            uart_elapsed_next[i] = '0;
                        end
                    end
                end

                mtt_pkg::ACT_CAPTURE:
                begin
                    for (int i = 0; i < CAPTURE_CHANNELS; i++)
                    begin
                        if (in_data_reg.channel == 3'(i))
                        begin
                            idle_next[i] = '0;
                        end
                    end
                end

                mtt_pkg::ACT_LOAD_DELAY:
                begin
                    startup_next = in_data_reg.delay_value;
                end

                default:
                begin
                end
            endcase
        end
    end

    // result assembly from the updated state
    always_comb
    begin
        out_data_next               = '0;
        out_data_next.pulse_10ms    = p10;
        out_data_next.pulse_100ms   = p100;
        out_data_next.pulse_1s      = p1s;
        out_data_next.pulse_1min    = p1min;
        out_data_next.scan_pulse    = scan_mode_reg ? p10 : p100;
        out_data_next.oneshot_busy  = shot_on_next;
        for (int i = 0; i < mtt_pkg::EXP_W; i++)
        begin
            if (i < UART_CHANNELS)
            begin
                out_data_next.uart_expired[i] = uart_fired[i];
            end
        end
        for (int i = 0; i < CAPTURE_CHANNELS; i++)
        begin
            out_data_next.capture_stale[i] = capture_use_reg[i]
                                             && (idle_next[i] >= idle_limit_reg);
        end
        out_data_next.startup_left  = startup_next;
        out_data_next.seconds_now   = sec_next;
        out_data_next.minutes_now   = min_next;
        out_data_next.millis_now    = ms_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg           <= '0;
            ones_reg         <= '0;
            tens_reg         <= '0;
            sec_reg          <= '0;
            min_reg          <= '0;
            shot_on_reg      <= 1'b0;
            shot_elapsed_reg <= '0;
            uart_armed_reg   <= '0;
            startup_reg      <= '0;
            for (int i = 0; i < UART_CHANNELS; i++)
            begin
                uart_elapsed_reg[i] <= '0;
            end
            for (int i = 0; i < CAPTURE_CHANNELS; i++)
            begin
                idle_reg[i] <= '0;
            end
        end
        else
        begin
            ms_reg           <= ms_next;
            ones_reg         <= ones_next;
            tens_reg         <= tens_next;
            sec_reg          <= sec_next;
            min_reg          <= min_next;
            shot_on_reg      <= shot_on_next;
            shot_elapsed_reg <= shot_elapsed_next;
            uart_armed_reg   <= uart_armed_next;
            startup_reg      <= startup_next;
            uart_elapsed_reg <= uart_elapsed_next;
            idle_reg         <= idle_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: verif/timebase_checker.sv
// checker for the millisecond timebase: predicts each reading and compares it
`timescale 1ns / 100ps

module timebase_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic                       item_stall,
    input  mtt_pkg::item_t             item,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  mtt_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [mtt_pkg::ADDR_W-1:0] paddr,
    input  logic [mtt_pkg::DATA_W-1:0] pwdata,
    output int                         mismatch_total,
    output int                         readings_open
);

    localparam int TEN_MS     = 10;
    localparam int HUNDRED_MS = 100;

    // register copies
    logic                        scan_fast;
    logic [mtt_pkg::STALE_W-1:0] cap_mask;
    logic [mtt_pkg::UART_W-1:0]  uart_limit;
    logic [mtt_pkg::IDLE_W-1:0]  idle_limit;
    logic [mtt_pkg::SHOT_W-1:0]  shot_len;

    // timebase state
    logic [mtt_pkg::MS_W-1:0]    ms_cnt;
    logic [mtt_pkg::TIME_W-1:0]  sec_cnt;
    logic [mtt_pkg::TIME_W-1:0]  min_cnt;
    logic                        shot_on;
    logic [mtt_pkg::SHOT_W-1:0]  shot_cnt;
    logic                        uart_armed [mtt_pkg::UART_CHANNELS_DEF];
    logic [mtt_pkg::UART_W-1:0]  uart_cnt   [mtt_pkg::UART_CHANNELS_DEF];
    logic [mtt_pkg::IDLE_W-1:0]  cap_idle   [mtt_pkg::CAPTURE_CHANNELS_DEF];
    logic [mtt_pkg::DELAY_W-1:0] startup_cnt;

    mtt_pkg::result_t timebase_readings[$];
    int               fail_count;

    // apply one transaction to the timebase and form the reading it gives
    task automatic apply_event(input mtt_pkg::item_t ev, output mtt_pkg::result_t rd);
        int i;
        begin
            rd = '0;
            case (ev.action)
                mtt_pkg::ACT_TICK:
                begin
                    ms_cnt = ms_cnt + 1'b1;
                    if (shot_on)
                    begin
                        shot_cnt = shot_cnt + 1'b1;
                        if (shot_cnt >= shot_len)
                        begin
                            shot_cnt = '0;
                            shot_on  = 1'b0;
                        end
                    end
                    for (i = 0; i < mtt_pkg::UART_CHANNELS_DEF; i++)
                    begin
                        if (uart_armed[i])
                        begin
                            if (uart_cnt[i] < uart_limit)
                                uart_cnt[i] = uart_cnt[i] + 1'b1;
                            else
                            begin
                                uart_cnt[i]        = '0;
                                uart_armed[i]      = 1'b0;
                                rd.uart_expired[i] = 1'b1;
                            end
                        end
                    end
                    if (ms_cnt % TEN_MS == 0)
                    begin
                        rd.pulse_10ms = 1'b1;
                        if (scan_fast)
                            rd.scan_pulse = 1'b1;
                    end
                    if (ms_cnt % HUNDRED_MS == 0)
                    begin
                        rd.pulse_100ms = 1'b1;
                        if (!scan_fast)
                            rd.scan_pulse = 1'b1;
                    end
                    // second boundary
                    if (ms_cnt > mtt_pkg::MS_LAST)
                    begin
                        for (i = 0; i < mtt_pkg::CAPTURE_CHANNELS_DEF; i++)
                        begin
                            if (cap_mask[i] && cap_idle[i] < idle_limit)
                                cap_idle[i] = cap_idle[i] + 1'b1;
                        end
                        ms_cnt      = '0;
                        rd.pulse_1s = 1'b1;
                        if (startup_cnt != '0)
                            startup_cnt = startup_cnt - 1'b1;
                        sec_cnt = sec_cnt + 1'b1;
                        if (sec_cnt > mtt_pkg::SIXTY_LAST)
                        begin
                            sec_cnt       = '0;
                            rd.pulse_1min = 1'b1;
                            min_cnt       = min_cnt + 1'b1;
                            if (min_cnt > mtt_pkg::SIXTY_LAST)
                                min_cnt = '0;
                        end
                    end
                end
                mtt_pkg::ACT_ARM_ONESHOT:
                begin
                    shot_on  = 1'b1;
                    shot_cnt = '0;
                end
                mtt_pkg::ACT_ARM_UART:
                begin
                    if (ev.channel < mtt_pkg::UART_CHANNELS_DEF)
                    begin
                        uart_armed[ev.channel] = 1'b1;
                        uart_cnt[ev.channel]   = '0;
                    end
                end
                mtt_pkg::ACT_CAPTURE:
                begin
                    if (ev.channel < mtt_pkg::CAPTURE_CHANNELS_DEF)
                        cap_idle[ev.channel] = '0;
                end
                mtt_pkg::ACT_LOAD_DELAY:
                    startup_cnt = ev.delay_value;
                default:
                    ;
            endcase

            for (i = 0; i < mtt_pkg::CAPTURE_CHANNELS_DEF; i++)
            begin
                if (cap_mask[i] && cap_idle[i] >= idle_limit)
                    rd.capture_stale[i] = 1'b1;
            end
            rd.oneshot_busy = shot_on;
            rd.startup_left = startup_cnt;
            rd.seconds_now  = sec_cnt;
            rd.minutes_now  = min_cnt;
            rd.millis_now   = ms_cnt;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] seen);
        begin
            if (seen !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
                fail_count++;
            end
        end
    endtask

    // match an accepted reading against the oldest prediction
    task automatic check_reading(input mtt_pkg::result_t got);
        mtt_pkg::result_t want;
        begin
            if (timebase_readings.size() == 0)
            begin
                $error("reading with no transaction waiting for it");
                fail_count++;
            end
            else
            begin
                want = timebase_readings.pop_front();
                compare_field("pulse_10ms",    32'(want.pulse_10ms),    32'(got.pulse_10ms));
                compare_field("pulse_100ms",   32'(want.pulse_100ms),   32'(got.pulse_100ms));
                compare_field("pulse_1s",      32'(want.pulse_1s),      32'(got.pulse_1s));
                compare_field("pulse_1min",    32'(want.pulse_1min),    32'(got.pulse_1min));
                compare_field("scan_pulse",    32'(want.scan_pulse),    32'(got.scan_pulse));
                compare_field("oneshot_busy",  32'(want.oneshot_busy),  32'(got.oneshot_busy));
                compare_field("uart_expired",  32'(want.uart_expired),  32'(got.uart_expired));
                compare_field("capture_stale", 32'(want.capture_stale),
                              32'(got.capture_stale));
                compare_field("startup_left",  32'(want.startup_left),  32'(got.startup_left));
                compare_field("seconds_now",   32'(want.seconds_now),   32'(got.seconds_now));
                compare_field("minutes_now",   32'(want.minutes_now),   32'(got.minutes_now));
                compare_field("millis_now",    32'(want.millis_now),    32'(got.millis_now));
            end
        end
    endtask

    // watch config, item and result channels
    always @(posedge clk or negedge rst_n)
    begin
        mtt_pkg::result_t rd;
        if (!rst_n)
        begin
            scan_fast   = mtt_pkg::SCAN_MODE_RST;
            cap_mask    = mtt_pkg::CAPTURE_USE_RST;
            uart_limit  = mtt_pkg::UART_LIMIT_RST;
            idle_limit  = mtt_pkg::IDLE_LIMIT_RST;
            shot_len    = mtt_pkg::ONESHOT_LEN_RST;
            ms_cnt      = '0;
            sec_cnt     = '0;
            min_cnt     = '0;
            shot_on     = 1'b0;
            shot_cnt    = '0;
            startup_cnt = '0;
            for (int k = 0; k < mtt_pkg::UART_CHANNELS_DEF; k++)
            begin
                uart_armed[k] = 1'b0;
                uart_cnt[k]   = '0;
            end
            for (int k = 0; k < mtt_pkg::CAPTURE_CHANNELS_DEF; k++)
                cap_idle[k] = '0;
            timebase_readings.delete();
            fail_count = 0;
        end
        else
        begin
            // register write on the access cycle
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[mtt_pkg::ADDR_W-1:2])
                    mtt_pkg::REG_SCAN_MODE:   scan_fast  = pwdata[0];
                    mtt_pkg::REG_CAPTURE_USE: cap_mask   = pwdata[mtt_pkg::STALE_W-1:0];
                    mtt_pkg::REG_UART_LIMIT:  uart_limit = pwdata[mtt_pkg::UART_W-1:0];
                    mtt_pkg::REG_IDLE_LIMIT:  idle_limit = pwdata[mtt_pkg::IDLE_W-1:0];
                    mtt_pkg::REG_ONESHOT_LEN: shot_len   = pwdata[mtt_pkg::SHOT_W-1:0];
                    default:                  ;
                endcase
            end
            if (result_valid && !result_stall)
                check_reading(result);
            if (item_valid && !item_stall)
            begin
                apply_event(item, rd);
                timebase_readings.push_back(rd);
            end
        end
        mismatch_total <= fail_count;
        readings_open  <= timebase_readings.size();
    end

endmodule

FILE: verif/testbench.sv
// top of the millisecond timebase testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;

    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       item_valid   = 1'b0;
    logic                       item_stall;
    mtt_pkg::item_t             item         = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    mtt_pkg::result_t           result;
    logic                       psel         = 1'b0;
    logic                       penable      = 1'b0;
    logic                       pwrite       = 1'b0;
    logic [mtt_pkg::ADDR_W-1:0] paddr        = '0;
    logic [mtt_pkg::DATA_W-1:0] pwdata       = '0;
    logic [mtt_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    int mismatch_total;
    int readings_open;
    int burst_left = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          stall_step = 0;

    millisecond_timebase_and_timeouts_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    timebase_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_total (mismatch_total),
        .readings_open  (readings_open)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // receiver stall pattern, switching between modes
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(50, 300);
        end
        else
            stall_left--;
        stall_step++;
        case (stall_mode)
            STALL_NONE:     result_stall <= 1'b0;
            STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
            default:        result_stall <= ((stall_step % 7) < 3);
        endcase
    end

    function automatic mtt_pkg::item_t make_item(input logic [2:0] act,
                                                 input logic [2:0] chan,
                                                 input logic [mtt_pkg::DELAY_W-1:0] delay);
        mtt_pkg::item_t it;
        begin
            it.action      = act;
            it.channel     = chan;
            it.delay_value = delay;
            return it;
        end
    endfunction

    // present one transaction, with bursts and random gaps between them
    task automatic send_item(input mtt_pkg::item_t it);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 10);
                if (gap > 0)
                begin
                    item_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 12);
            end
            item       <= it;
            item_valid <= 1'b1;
            do
                @(posedge clk);
            while (item_stall);
            burst_left--;
        end
    endtask

    // hold off until every predicted reading has come back
    task automatic drain_results();
        begin
            item_valid <= 1'b0;
            burst_left = 0;
            @(posedge clk);
            while (readings_open != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [mtt_pkg::DATA_W-1:0] data);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= data;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
        end
    endtask

    task automatic load_settings(input logic scan, input logic [mtt_pkg::STALE_W-1:0] mask,
                                 input logic [mtt_pkg::UART_W-1:0] uart_lim,
                                 input logic [mtt_pkg::IDLE_W-1:0] idle_lim,
                                 input logic [mtt_pkg::SHOT_W-1:0] shot);
        begin
            write_reg(mtt_pkg::REG_SCAN_MODE,   mtt_pkg::DATA_W'(scan));
            write_reg(mtt_pkg::REG_CAPTURE_USE, mtt_pkg::DATA_W'(mask));
            write_reg(mtt_pkg::REG_UART_LIMIT,  mtt_pkg::DATA_W'(uart_lim));
            write_reg(mtt_pkg::REG_IDLE_LIMIT,  mtt_pkg::DATA_W'(idle_lim));
            write_reg(mtt_pkg::REG_ONESHOT_LEN, mtt_pkg::DATA_W'(shot));
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
        end
    endtask

    // mostly ticks, with arming, capture and delay-load events and some ignored actions mixed in
    task automatic run_random(input int count, input int pause_at);
        int             sent;
        int             pick;
        mtt_pkg::item_t it;
        begin
            sent = 0;
            while (sent < count)
            begin
                it.action      = mtt_pkg::ACT_TICK;
                it.channel     = 3'($urandom);
                it.delay_value = mtt_pkg::DELAY_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 74)
                    it.action = mtt_pkg::ACT_TICK;
                else if (pick < 80)
                    it.action = mtt_pkg::ACT_ARM_ONESHOT;
                else if (pick < 87)
                begin
                    it.action = mtt_pkg::ACT_ARM_UART;
                    if ($urandom_range(0, 4) != 0)
                        it.channel = 3'($urandom_range(0, mtt_pkg::UART_CHANNELS_DEF - 1));
                end
                else if (pick < 93)
                    it.action = mtt_pkg::ACT_CAPTURE;
                else if (pick < 97)
                begin
                    it.action = mtt_pkg::ACT_LOAD_DELAY;
                    if ($urandom_range(0, 2) != 0)
                        it.delay_value = mtt_pkg::DELAY_W'($urandom_range(0, 4));
                end
                else
                    it.action = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
                send_item(it);
                if (it.action <= mtt_pkg::ACT_LOAD_DELAY)
                begin
                    sent++;
                    if (sent == pause_at)
                        drain_results();
                end
            end
        end
    endtask

    // stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every action, channel ends, delay extremes, ignored actions
        send_item(make_item(mtt_pkg::ACT_TICK, 3'd0, '0));
        send_item(make_item(mtt_pkg::ACT_ARM_ONESHOT, 3'd0, '0));
        send_item(make_item(mtt_pkg::ACT_ARM_UART, 3'd0, '0));
        send_item(make_item(mtt_pkg::ACT_ARM_UART, 3'd1, '0));
        send_item(make_item(mtt_pkg::ACT_ARM_UART, 3'd7, '1));
        send_item(make_item(mtt_pkg::ACT_CAPTURE, 3'd0, '0));
        send_item(make_item(mtt_pkg::ACT_CAPTURE, 3'd7, '0));
        send_item(make_item(mtt_pkg::ACT_LOAD_DELAY, 3'd0, '1));
        send_item(make_item(mtt_pkg::ACT_LOAD_DELAY, 3'd0, '0));
        send_item(make_item(mtt_pkg::ACT_LOAD_DELAY, 3'd0, mtt_pkg::DELAY_W'(1)));
        for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
            send_item(make_item(3'(a), 3'd7, '1));
        // run past the 10 ms mark and the default uart timeout
        repeat (12) send_item(make_item(mtt_pkg::ACT_TICK, 3'd0, '0));

        // defaults from reset
        run_random(380, -1);
        drain_results();

        // low extremes
        load_settings(1'b0, 8'hFF, '0, '0, '0);
        run_random(385, -1);
        drain_results();

        // high extremes
        load_settings(1'b1, 8'h5A, '1, '1, '1);
        run_random(385, -1);
        drain_results();

        // short timeouts, with a full pause midway
        load_settings(1'b0, mtt_pkg::STALE_W'($urandom), mtt_pkg::UART_W'(3),
                      mtt_pkg::IDLE_W'(1), mtt_pkg::SHOT_W'($urandom_range(1, 40)));
        run_random(385, 190);
        drain_results();

        // random moderate settings
        load_settings(1'b1, mtt_pkg::STALE_W'($urandom),
                      mtt_pkg::UART_W'($urandom_range(0, 25)),
                      mtt_pkg::IDLE_W'($urandom_range(0, 2)),
                      mtt_pkg::SHOT_W'($urandom_range(1, 300)));
        run_random(385, -1);
        drain_results();

        if (mismatch_total == 0 && readings_open == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
